// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the joint command hold controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/jchc_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and joint tables of the joint command hold controller.
package jchc_pkg;

  localparam int unsigned JOINTS_DEF = 7;
  localparam int unsigned ROBOTS_DEF = 4;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TRQ_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_LIMIT   = 3'd4;

  localparam logic [15:0] KP_SCALE_RESET = 16'd256;
  localparam logic [15:0] KD_SCALE_RESET = 16'd256;
  localparam logic [30:0] EXT_LIMIT_RESET = 31'd3932160;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               op;
    logic [1:0]         robot;
    logic [2:0]         joint;
    logic signed [31:0] measured_position;
    logic signed [31:0] estimated_velocity;
    logic signed [31:0] commanded_position;
    logic signed [31:0] commanded_torque;
    logic               position_cmd_present;
    logic               torque_cmd_present;
    logic               command_expired;
    logic               client_torque_mode;
    logic signed [31:0] external_torque;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] joint_position_out;
    logic signed [31:0] joint_torque_out;
    logic               torque_out_valid;
    logic               holding;
    logic               unsafe;
  } out_item_t;

  function automatic logic [2:0] table_joint(input logic [2:0] joint);
    table_joint = (joint > 3'd6) ? 3'd6 : joint;
  endfunction

  function automatic logic [3:0] lim_tenths(input logic [2:0] t);
    unique case (t)
      3'd0, 3'd1, 3'd2: lim_tenths = 4'd10;
      3'd3:             lim_tenths = 4'd5;
      3'd4, 3'd5:       lim_tenths = 4'd2;
      default:          lim_tenths = 4'd1;
    endcase
  endfunction

  function automatic logic signed [31:0] pos_bound(input logic [2:0] t);
    unique case (t)
      3'd0, 3'd2, 3'd4: pos_bound = 32'sd49486184;
      3'd1, 3'd3, 3'd5: pos_bound = 32'sd34845301;
      default:          pos_bound = 32'sd50950273;
    endcase
  endfunction

  function automatic logic [9:0] gain_p(input logic [2:0] t);
    unique case (t)
      3'd0, 3'd1, 3'd2: gain_p = 10'd1000;
      default:          gain_p = 10'd500;
    endcase
  endfunction

  function automatic logic [5:0] gain_d(input logic [2:0] t);
    unique case (t)
      3'd0, 3'd1, 3'd2, 3'd3: gain_d = 6'd50;
      default:                gain_d = 6'd35;
    endcase
  endfunction

endpackage

// ===== rtl/core/joint_command_hold_controller_unit.sv =====
`timescale 1ns / 1ps
// Top level of the joint command hold controller.
//
// Each input transaction carries one joint of one robot: an enter-command-state
// event or a command tick. Every accepted transaction gives exactly one result
// transaction on the output channel, in order. Events latch the hold position
// and yield an all-zero result; ticks give the position and torque to drive.
// The hold positions live in a RAM of ROBOTS*JOINTS words with a registered read;
// the per-robot entry and expiry flags live in flip-flops.
// An item is accepted in the idle state and passes through three further steps:
// hold read and control decisions, the holding-gain multiplications, and the
// rounding and saturation of the holding torque. The result is loaded into the
// output register in the last step, and a new item is taken only back in idle.
// in_stall is high while an item is in progress. The output register keeps a
// finished result while out_stall is high; a following item then waits in its
// last step until that register is free.
// Synchronous reset clears the flags and both handshakes and returns the
// configuration registers to their defaults; the RAM is not cleared.
`include "assert_macros.svh"
module joint_command_hold_controller_unit #(
  parameter int unsigned JOINTS = jchc_pkg::JOINTS_DEF,
  parameter int unsigned ROBOTS = jchc_pkg::ROBOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  jchc_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output jchc_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [jchc_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [jchc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned DEPTH = ROBOTS * JOINTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
  localparam int unsigned IW    = 7;

  localparam logic signed [61:0] SAT_MAX = 62'sd2147483647;
  localparam logic signed [61:0] SAT_MIN = -62'sd2147483648;
  localparam logic signed [61:0] ROUND_HALF = 62'sd32768;

  jchc_pkg::state_t state_r, state_nxt;

  logic        trq_mode_r, restart_r;
  logic [15:0] kp_scale_r, kd_scale_r;
  logic [30:0] ext_limit_r;

  logic [ROBOTS-1:0] entered_r, entered_nxt;
  logic [ROBOTS-1:0] inhib_r, inhib_nxt;
  logic [ROBOTS-1:0] warned_r, warned_nxt;
  logic [ROBOTS-1:0] latch_r, latch_nxt;

  jchc_pkg::in_item_t  item_r;
  logic [AW-1:0]       idx_r;
  jchc_pkg::out_item_t res_r, res_nxt;
  jchc_pkg::out_item_t res_fin;
  jchc_pkg::out_item_t out_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                pd_sel_r, pd_sel_nxt;
  logic signed [32:0]  err_r, err_nxt;
  logic [25:0]         gp_r, gp_nxt;
  logic [21:0]         gd_r, gd_nxt;
  logic signed [59:0]  prod_p_r, prod_p_nxt;
  logic signed [54:0]  prod_d_r, prod_d_nxt;

  logic                in_accept;
  logic                out_load;
  logic [IW-1:0]       idx_wide;
  logic [AW-1:0]       rd_addr;
  logic [31:0]         rd_data;
  logic                ram_we;

  logic                in_range;
  logic                is_tick;
  logic [RW-1:0]       rsel;
  logic [2:0]          tj;
  logic                cmd_valid;
  logic                latch_eff;
  logic                hold_sel;
  logic signed [31:0]  hold_val;
  logic signed [31:0]  bound;
  logic signed [31:0]  clamped;
  logic [32:0]         ext_neg;
  logic [31:0]         ext_mag;
  logic [35:0]         lhs, rhs;

  logic signed [26:0]  gp_s;
  logic signed [22:0]  gd_s;
  logic signed [60:0]  pd_sum;
  logic signed [61:0]  pd_x;
  logic signed [61:0]  pd_sh;
  logic signed [31:0]  pd_sat;

  assign idx_wide = IW'(in_data.robot) * IW'(JOINTS) + IW'(in_data.joint);
  assign rd_addr  = idx_wide[AW-1:0];

  jchc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (item_r.measured_position),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // State machine: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jchc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = jchc_pkg::ST_GAIN;
        end
      end
      jchc_pkg::ST_GAIN: state_nxt = jchc_pkg::ST_MUL;
      jchc_pkg::ST_MUL:  state_nxt = jchc_pkg::ST_FIN;
      jchc_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = jchc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jchc_pkg::ST_IDLE;
    endcase
  end

  // State machine: outputs.
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      jchc_pkg::ST_IDLE: in_stall = 1'b0;
      jchc_pkg::ST_GAIN: in_stall = 1'b1;
      jchc_pkg::ST_MUL:  in_stall = 1'b1;
      jchc_pkg::ST_FIN:  out_load = !out_valid_r || !out_stall;
      default:           in_stall = 1'b1;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // Hold read, flag update and result selection.
  always_comb begin
    in_range  = (32'(item_r.robot) < ROBOTS) && (32'(item_r.joint) < JOINTS);
    is_tick   = (item_r.op == jchc_pkg::OP_TICK);
    rsel      = RW'(item_r.robot);
    tj        = jchc_pkg::table_joint(item_r.joint);
    cmd_valid = item_r.position_cmd_present && item_r.torque_cmd_present;

    entered_nxt = entered_r;
    inhib_nxt   = inhib_r;
    warned_nxt  = warned_r;
    latch_nxt   = latch_r;
    latch_eff   = latch_r[rsel];

    if ((state_r == jchc_pkg::ST_GAIN) && in_range) begin
      if (!is_tick) begin
        if (item_r.joint == 3'd0) begin
          if (!entered_r[rsel]) begin
            entered_nxt[rsel] = 1'b1;
          end else if (!restart_r) begin
            inhib_nxt[rsel] = 1'b1;
          end
        end
      end else if (!trq_mode_r) begin
        if (item_r.joint == 3'd0) begin
          latch_nxt[rsel] = 1'b0;
        end
      end else if (item_r.joint == 3'd0) begin
        if (cmd_valid && item_r.command_expired) begin
          latch_nxt[rsel]  = !warned_r[rsel];
          warned_nxt[rsel] = 1'b1;
          latch_eff        = !warned_r[rsel];
        end else begin
          latch_nxt[rsel]  = 1'b0;
          warned_nxt[rsel] = 1'b0;
          latch_eff        = 1'b0;
        end
      end
    end

    ram_we = (state_r == jchc_pkg::ST_GAIN) && in_range &&
             (!is_tick || (trq_mode_r && latch_eff));

    hold_val = (trq_mode_r && latch_eff) ? item_r.measured_position : $signed(rd_data);
    if (trq_mode_r) begin
      hold_sel = inhib_r[rsel] || !(cmd_valid && !item_r.command_expired);
    end else begin
      hold_sel = inhib_r[rsel] || !item_r.position_cmd_present;
    end

    bound = jchc_pkg::pos_bound(tj);
    if (item_r.commanded_position > bound) begin
      clamped = bound;
    end else if (item_r.commanded_position < -bound) begin
      clamped = -bound;
    end else begin
      clamped = item_r.commanded_position;
    end

    ext_neg = 33'd0 - {item_r.external_torque[31], item_r.external_torque};
    ext_mag = item_r.external_torque[31] ? ext_neg[31:0] : item_r.external_torque;
    lhs     = 36'(ext_mag) * 36'd10;
    rhs     = 36'(ext_limit_r) * 36'(jchc_pkg::lim_tenths(tj));

    res_nxt    = '0;
    pd_sel_nxt = 1'b0;
    if (is_tick && in_range) begin
      res_nxt.unsafe  = (lhs > rhs);
      res_nxt.holding = hold_sel;
      if (!trq_mode_r) begin
        res_nxt.joint_position_out = hold_sel ? $signed(rd_data) : clamped;
        res_nxt.torque_out_valid   = item_r.client_torque_mode;
        res_nxt.joint_torque_out   = (item_r.client_torque_mode && !hold_sel &&
                                      item_r.torque_cmd_present) ?
                                     item_r.commanded_torque : 32'sd0;
      end else begin
        res_nxt.joint_position_out = item_r.measured_position;
        res_nxt.torque_out_valid   = 1'b1;
        res_nxt.joint_torque_out   = item_r.commanded_torque;
        pd_sel_nxt                 = hold_sel;
      end
    end

    err_nxt = 33'(item_r.measured_position) - 33'(hold_val);
    gp_nxt  = 26'(jchc_pkg::gain_p(tj)) * 26'(kp_scale_r);
    gd_nxt  = 22'(jchc_pkg::gain_d(tj)) * 22'(kd_scale_r);
  end

  // Holding-gain products.
  always_comb begin
    gp_s       = $signed({1'b0, gp_r});
    gd_s       = $signed({1'b0, gd_r});
    prod_p_nxt = gp_s * err_r;
    prod_d_nxt = gd_s * item_r.estimated_velocity;
  end

  // Sum, negate, round half up and saturate the holding torque.
  always_comb begin
    pd_sum = 61'(prod_p_r) + 61'(prod_d_r);
    pd_x   = -(62'(pd_sum)) + ROUND_HALF;
    pd_sh  = pd_x >>> 16;
    if (pd_sh > SAT_MAX) begin
      pd_sat = 32'sh7FFFFFFF;
    end else if (pd_sh < SAT_MIN) begin
      pd_sat = 32'sh80000000;
    end else begin
      pd_sat = pd_sh[31:0];
    end
  end

  always_comb begin
    res_fin = res_r;
    if (pd_sel_r) begin
      res_fin.joint_torque_out = pd_sat;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= jchc_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      entered_r     <= '0;
      inhib_r       <= '0;
      warned_r      <= '0;
      latch_r       <= '0;
      trq_mode_r    <= 1'b0;
      restart_r     <= 1'b0;
      kp_scale_r    <= jchc_pkg::KP_SCALE_RESET;
      kd_scale_r    <= jchc_pkg::KD_SCALE_RESET;
      ext_limit_r   <= jchc_pkg::EXT_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      entered_r   <= entered_nxt;
      inhib_r     <= inhib_nxt;
      warned_r    <= warned_nxt;
      latch_r     <= latch_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          jchc_pkg::CFG_TRQ_MODE:    trq_mode_r    <= cfg_wdata[0];
          jchc_pkg::CFG_RESTART:     restart_r     <= cfg_wdata[0];
          jchc_pkg::CFG_KP_SCALE:    kp_scale_r    <= cfg_wdata[15:0];
          jchc_pkg::CFG_KD_SCALE:    kd_scale_r    <= cfg_wdata[15:0];
          jchc_pkg::CFG_EXT_LIMIT:   ext_limit_r   <= cfg_wdata;
          default:                   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
      idx_r  <= rd_addr;
    end
    if (state_r == jchc_pkg::ST_GAIN) begin
      res_r    <= res_nxt;
      pd_sel_r <= pd_sel_nxt;
      err_r    <= err_nxt;
      gp_r     <= gp_nxt;
      gd_r     <= gd_nxt;
    end
    if (state_r == jchc_pkg::ST_MUL) begin
      prod_p_r <= prod_p_nxt;
      prod_d_r <= prod_d_nxt;
    end
    if (out_load) begin
      out_data_r <= res_fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, state_r == jchc_pkg::ST_GAIN)
  `ASSERT_IMPLIES(a_write_in_gain, clk, rst_n, ram_we, state_r == jchc_pkg::ST_GAIN)
  `ASSERT_IMPLIES(a_inhibit_sticky, clk, rst_n, $past(rst_n), (inhib_r & $past(inhib_r)) == $past(inhib_r))
  `ASSERT_IMPLIES(a_out_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == jchc_pkg::ST_FIN)

endmodule

// ===== rtl/core/jchc_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
module jchc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 28,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
